// ===== design/rrs_pkg.sv =====
// ----------------------------------------------------------------------------
// rrs_pkg
// Shared types and fixed field widths for the round-robin schedule core.
// ----------------------------------------------------------------------------
package rrs_pkg;

  // Result field widths (fixed by the result item format)
  localparam int PIDX_W    = 4;
  localparam int OUT_W     = 21;
  localparam int Q_W       = 16;
  localparam int M_TDATA_W = 72;
  localparam int PAD_W     = M_TDATA_W - PIDX_W - 3 * OUT_W;

  localparam logic [Q_W-1:0] QUANTUM_RST = Q_W'(3);

  // Sequencer states, one-hot
  typedef enum logic [15:0] {
    S_LOAD     = 16'h0001,
    S_RK_A     = 16'h0002,
    S_RK_CAP   = 16'h0004,
    S_RK_SCAN  = 16'h0008,
    S_RK_WR    = 16'h0010,
    S_TOP      = 16'h0020,
    S_JUMP     = 16'h0040,
    S_POP      = 16'h0080,
    S_SLICE    = 16'h0100,
    S_END      = 16'h0200,
    S_ENQ_RD   = 16'h0400,
    S_ENQ_CHK  = 16'h0800,
    S_WB       = 16'h1000,
    S_OUT_RD   = 16'h2000,
    S_OUT_CALC = 16'h4000,
    S_OUT_FILL = 16'h8000
  } state_t;

endpackage

// ===== design/round_robin_schedule_simulator_core.sv =====
// ----------------------------------------------------------------------------
// round_robin_schedule_simulator_core
// Loads a set of processes, simulates round-robin scheduling, and streams
// out completion, turnaround and waiting time per process.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one item per process, tdata = {burst_time, arrival_time},
//   tlast marks the final process of the set and starts the run. Items past
//   MAX_PROCS are dropped and flag overflow on every result of that set.
//   Master stream: one result per loaded process, in load order; tlast on the
//   final result, tuser carries the overflow flag.
//   cfg_wr_en/cfg_wr_data write the time quantum (0 acts as 1); write it only
//   while the block is idle.
// Flow:
//   Loading takes one item per cycle. After the last item, s_tready drops:
//   an arrival sort runs (one port on the process memory, one compare per
//   cycle), then the time slices are simulated, then the results stream out.
//   The final result sits in the output register while loading of the next
//   set already runs.
// Reset: synchronous, active high; returns to loading, quantum = 3, output
//   empty. Memories are not cleared; every entry is written before it is read.
// Stall: a low m_tready freezes the result in the output register and the
//   sequencer waits before filling the next one.
// ----------------------------------------------------------------------------
module round_robin_schedule_simulator_core #(
  parameter int MAX_PROCS = 16,
  parameter int TIME_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration: time_quantum
  input  logic                                  cfg_wr_en,
  input  logic [rrs_pkg::Q_W-1:0]               cfg_wr_data,
  // slave stream
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // [TIME_BITS-1:0] arrival_time, [2*TIME_BITS-1:TIME_BITS] burst_time, zero pad
  input  logic [((2*TIME_BITS+7)/8)*8-1:0]      s_tdata,
  input  logic                                  s_tlast,   // last_process
  // master stream
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // [3:0] process_index, [24:4] completion_time, [45:25] turnaround_time,
  // [66:46] waiting_time, [71:67] zero
  output logic [rrs_pkg::M_TDATA_W-1:0]         m_tdata,
  output logic                                  m_tlast,   // last_result
  output logic                                  m_tuser    // overflow
);

  localparam int IdxW   = $clog2(MAX_PROCS);
  localparam int CntW   = $clog2(MAX_PROCS + 1);
  localparam int CtW    = TIME_BITS + CntW;        // holds any finish tick
  localparam int LAddrW = IdxW + 1;                // fifo half + sorted half
  localparam int QcW    = (TIME_BITS > rrs_pkg::Q_W) ? TIME_BITS : rrs_pkg::Q_W;
  localparam int OutW   = rrs_pkg::OUT_W;
  localparam int PidxW  = rrs_pkg::PIDX_W;
  localparam int PadW   = rrs_pkg::PAD_W;

  typedef struct packed {
    logic [CtW-1:0]       ct;
    logic [TIME_BITS-1:0] rem;
    logic [TIME_BITS-1:0] bur;
    logic [TIME_BITS-1:0] arr;
  } proc_ent_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] arr;
    logic [IdxW-1:0]      idx;
  } list_ent_t;

  // Process table and list memory (ready fifo low half, arrival order high half)
  proc_ent_t proc_mem [MAX_PROCS];
  list_ent_t list_mem [2**LAddrW];

  proc_ent_t         proc_rdata;
  proc_ent_t         proc_wdata;
  logic [IdxW-1:0]   proc_raddr;
  logic [IdxW-1:0]   proc_waddr;
  logic              proc_we;
  list_ent_t         list_rdata;
  list_ent_t         list_wdata;
  logic [LAddrW-1:0] list_raddr;
  logic [LAddrW-1:0] list_waddr;
  logic              list_we;

  rrs_pkg::state_t state;

  logic [rrs_pkg::Q_W-1:0] quantum;
  logic [CntW-1:0]         n_cnt;
  logic                    ovf;
  logic [IdxW-1:0]         i_idx;
  logic [CntW-1:0]         j_cnt;
  logic [IdxW-1:0]         rank;
  logic [TIME_BITS-1:0]    a_i;
  logic [CtW-1:0]          time_cur;
  logic [IdxW-1:0]         head;
  logic [IdxW-1:0]         tail;
  logic [CntW-1:0]         fcnt;
  logic [CntW-1:0]         done_cnt;
  logic [CntW-1:0]         p_cnt;
  logic [CtW-1:0]          enq_lim;
  logic                    enq_slice;
  logic [IdxW-1:0]         cur;
  proc_ent_t               cur_ent;
  logic [TIME_BITS-1:0]    slice_r;
  logic                    fin_r;
  logic [CtW-1:0]          end_r;
  logic [IdxW-1:0]         k_idx;
  logic [CtW-1:0]          tat_r;
  logic [TIME_BITS-1:0]    bur_r;

  logic                    s_acc;
  logic [TIME_BITS-1:0]    in_arr;
  logic [TIME_BITS-1:0]    in_bur;
  logic [rrs_pkg::Q_W-1:0] qeff;
  logic [QcW-1:0]          rem_x;
  logic [QcW-1:0]          q_x;
  logic [IdxW-1:0]         jj;
  logic                    rk_lt;
  logic                    enq_hit;
  logic                    out_free;
  logic [CtW-1:0]          wt;
  logic [IdxW-1:0]         head_next;
  logic [IdxW-1:0]         tail_next;

  assign s_tready = (state == rrs_pkg::S_LOAD);
  assign s_acc    = s_tvalid && s_tready;
  assign in_arr   = s_tdata[TIME_BITS-1:0];
  assign in_bur   = s_tdata[2*TIME_BITS-1:TIME_BITS];

  assign qeff  = (quantum == '0) ? rrs_pkg::Q_W'(1) : quantum;
  assign rem_x = QcW'(proc_rdata.rem);
  assign q_x   = QcW'(qeff);

  // rank compare: entry jj precedes i by arrival, then by index
  assign jj    = IdxW'(j_cnt - CntW'(1));
  assign rk_lt = (proc_rdata.arr < a_i) || ((proc_rdata.arr == a_i) && (jj < i_idx));

  assign enq_hit  = (CtW'(list_rdata.arr) <= enq_lim);
  assign out_free = !m_tvalid || m_tready;
  assign wt       = tat_r - CtW'(bur_r);

  assign head_next = (head == IdxW'(MAX_PROCS - 1)) ? '0 : head + IdxW'(1);
  assign tail_next = (tail == IdxW'(MAX_PROCS - 1)) ? '0 : tail + IdxW'(1);

  // memory address / write muxes
  always_comb begin
    proc_raddr = '0;
    list_raddr = '0;
    proc_we    = 1'b0;
    proc_waddr = cur;
    proc_wdata = '{ct: end_r, rem: cur_ent.rem - slice_r, bur: cur_ent.bur,
                   arr: cur_ent.arr};
    list_we    = 1'b0;
    list_waddr = {1'b0, tail};
    list_wdata = '{arr: a_i, idx: cur};
    case (state)
      rrs_pkg::S_LOAD: begin
        proc_we    = s_acc && (n_cnt < CntW'(MAX_PROCS));
        proc_waddr = n_cnt[IdxW-1:0];
        proc_wdata = '{ct: '0, rem: in_bur, bur: in_bur, arr: in_arr};
      end
      rrs_pkg::S_RK_A:    proc_raddr = i_idx;
      rrs_pkg::S_RK_CAP:  proc_raddr = '0;
      rrs_pkg::S_RK_SCAN: proc_raddr = j_cnt[IdxW-1:0];
      rrs_pkg::S_RK_WR: begin
        list_we    = 1'b1;
        list_waddr = {1'b1, rank};
        list_wdata = '{arr: a_i, idx: i_idx};
      end
      rrs_pkg::S_TOP: begin
        list_raddr = (fcnt == '0) ? {1'b1, p_cnt[IdxW-1:0]} : {1'b0, head};
      end
      rrs_pkg::S_POP:    proc_raddr = list_rdata.idx;
      rrs_pkg::S_ENQ_RD: list_raddr = {1'b1, p_cnt[IdxW-1:0]};
      rrs_pkg::S_ENQ_CHK: begin
        list_we    = enq_hit;
        list_wdata = '{arr: list_rdata.arr, idx: list_rdata.idx};
      end
      rrs_pkg::S_WB: begin
        proc_we = 1'b1;
        list_we = !fin_r;   // preempted process back to the tail
      end
      rrs_pkg::S_OUT_RD: proc_raddr = k_idx;
      default: begin
      end
    endcase
  end

  // memories: one write, one registered read each
  always_ff @(posedge clk) begin
    if (proc_we) begin
      proc_mem[proc_waddr] <= proc_wdata;
    end
    proc_rdata <= proc_mem[proc_raddr];
  end

  always_ff @(posedge clk) begin
    if (list_we) begin
      list_mem[list_waddr] <= list_wdata;
    end
    list_rdata <= list_mem[list_raddr];
  end

  // quantum register
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= rrs_pkg::QUANTUM_RST;
    end else if (cfg_wr_en) begin
      quantum <= cfg_wr_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == rrs_pkg::S_OUT_FILL && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rrs_pkg::S_OUT_FILL && out_free) begin
      m_tdata <= {{PadW{1'b0}}, OutW'(wt), OutW'(tat_r), OutW'(end_r), PidxW'(k_idx)};
      m_tlast <= (CntW'(k_idx) + CntW'(1) == n_cnt);
      m_tuser <= ovf;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rrs_pkg::S_LOAD;
      n_cnt     <= '0;
      ovf       <= 1'b0;
      i_idx     <= '0;
      j_cnt     <= '0;
      rank      <= '0;
      time_cur  <= '0;
      head      <= '0;
      tail      <= '0;
      fcnt      <= '0;
      done_cnt  <= '0;
      p_cnt     <= '0;
      enq_lim   <= '0;
      enq_slice <= 1'b0;
      k_idx     <= '0;
    end else begin
      case (state)
        rrs_pkg::S_LOAD: begin
          if (s_acc) begin
            if (n_cnt < CntW'(MAX_PROCS)) begin
              n_cnt <= n_cnt + CntW'(1);
            end else begin
              ovf <= 1'b1;
            end
            if (s_tlast) begin
              i_idx <= '0;
              rank  <= '0;
              state <= rrs_pkg::S_RK_A;
            end
          end
        end
        rrs_pkg::S_RK_A: state <= rrs_pkg::S_RK_CAP;
        rrs_pkg::S_RK_CAP: begin
          a_i   <= proc_rdata.arr;
          j_cnt <= CntW'(1);
          state <= rrs_pkg::S_RK_SCAN;
        end
        rrs_pkg::S_RK_SCAN: begin
          rank <= rank + IdxW'(rk_lt);
          if (j_cnt == n_cnt) begin
            state <= rrs_pkg::S_RK_WR;
          end else begin
            j_cnt <= j_cnt + CntW'(1);
          end
        end
        rrs_pkg::S_RK_WR: begin
          if (CntW'(i_idx) + CntW'(1) == n_cnt) begin
            // arrival order built: start the run at tick zero
            time_cur  <= '0;
            head      <= '0;
            tail      <= '0;
            fcnt      <= '0;
            done_cnt  <= '0;
            p_cnt     <= '0;
            enq_lim   <= '0;
            enq_slice <= 1'b0;
            state     <= rrs_pkg::S_ENQ_RD;
          end else begin
            i_idx <= i_idx + IdxW'(1);
            rank  <= '0;
            state <= rrs_pkg::S_RK_A;
          end
        end
        rrs_pkg::S_TOP: begin
          if (done_cnt == n_cnt) begin
            k_idx <= '0;
            state <= rrs_pkg::S_OUT_RD;
          end else if (fcnt == '0) begin
            state <= rrs_pkg::S_JUMP;   // idle CPU: skip to next arrival
          end else begin
            state <= rrs_pkg::S_POP;
          end
        end
        rrs_pkg::S_JUMP: begin
          time_cur  <= CtW'(list_rdata.arr);
          enq_lim   <= CtW'(list_rdata.arr);
          enq_slice <= 1'b0;
          state     <= rrs_pkg::S_ENQ_RD;
        end
        rrs_pkg::S_POP: begin
          cur   <= list_rdata.idx;
          head  <= head_next;
          fcnt  <= fcnt - CntW'(1);
          state <= rrs_pkg::S_SLICE;
        end
        rrs_pkg::S_SLICE: begin
          cur_ent <= proc_rdata;
          slice_r <= TIME_BITS'((rem_x <= q_x) ? rem_x : q_x);
          fin_r   <= (rem_x <= q_x);
          state   <= rrs_pkg::S_END;
        end
        rrs_pkg::S_END: begin
          end_r     <= time_cur + CtW'(slice_r);
          enq_lim   <= time_cur + CtW'(slice_r);
          enq_slice <= 1'b1;
          state     <= rrs_pkg::S_ENQ_RD;
        end
        rrs_pkg::S_ENQ_RD: begin
          if (p_cnt < n_cnt) begin
            state <= rrs_pkg::S_ENQ_CHK;
          end else begin
            state <= enq_slice ? rrs_pkg::S_WB : rrs_pkg::S_TOP;
          end
        end
        rrs_pkg::S_ENQ_CHK: begin
          if (enq_hit) begin
            tail  <= tail_next;
            fcnt  <= fcnt + CntW'(1);
            p_cnt <= p_cnt + CntW'(1);
            state <= rrs_pkg::S_ENQ_RD;
          end else begin
            state <= enq_slice ? rrs_pkg::S_WB : rrs_pkg::S_TOP;
          end
        end
        rrs_pkg::S_WB: begin
          time_cur <= end_r;
          if (fin_r) begin
            done_cnt <= done_cnt + CntW'(1);
          end else begin
            tail <= tail_next;
            fcnt <= fcnt + CntW'(1);
          end
          state <= rrs_pkg::S_TOP;
        end
        rrs_pkg::S_OUT_RD: state <= rrs_pkg::S_OUT_CALC;
        rrs_pkg::S_OUT_CALC: begin
          end_r <= proc_rdata.ct;
          tat_r <= proc_rdata.ct - CtW'(proc_rdata.arr);
          bur_r <= proc_rdata.bur;
          state <= rrs_pkg::S_OUT_FILL;
        end
        rrs_pkg::S_OUT_FILL: begin
          if (out_free) begin
            if (CntW'(k_idx) + CntW'(1) == n_cnt) begin
              n_cnt    <= '0;
              ovf      <= 1'b0;
              done_cnt <= '0;
              p_cnt    <= '0;
              state    <= rrs_pkg::S_LOAD;
            end else begin
              k_idx <= k_idx + IdxW'(1);
              state <= rrs_pkg::S_OUT_RD;
            end
          end
        end
        default: state <= rrs_pkg::S_LOAD;
      endcase
    end
  end

`ifndef SYNTHESIS
  // ready queue never holds more than the loaded set
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fcnt <= n_cnt)
    else $error("ready queue count exceeds loaded set");

  // an empty queue with unfinished work always has a future arrival left
  a_jump_valid: assert property (@(posedge clk) disable iff (rst)
    (state == rrs_pkg::S_TOP) && (fcnt == '0) && (done_cnt != n_cnt) |-> (p_cnt < n_cnt))
    else $error("idle queue with no pending arrival");

  // finished count and arrival pointer stay within the set
  a_done_bound: assert property (@(posedge clk) disable iff (rst)
    (done_cnt <= n_cnt) && (p_cnt <= n_cnt))
    else $error("run counters beyond loaded set");

  // a result is only filled after the run has finished every process
  a_fill_done: assert property (@(posedge clk) disable iff (rst)
    (state == rrs_pkg::S_OUT_FILL) |-> (done_cnt == n_cnt))
    else $error("result emitted before run finished");
`endif

endmodule
